// ===== hdl/sha256_pkg.sv =====
// Package for the SHA-256 byte stream hasher: round constants, initial hash
// values, and the round and schedule helper functions. No dependencies.
package sha256_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [63:0] BlockBits = 64'd512;

  typedef logic [31:0] word_t;
  typedef word_t vars_t [8];

  function automatic word_t rotr(input word_t v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t sched_word(input word_t w16, input word_t w15,
                                       input word_t w7, input word_t w2);
    word_t s0, s1;
    s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    sched_word = w16 + s0 + w7 + s1;
  endfunction

endpackage

// ===== hdl/sha256_core.sv =====
// Compression core: one SHA-256 round per cycle. The 16-word schedule window
// sits in a register array; depends on sha256_pkg.
module sha256_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,   // pulse: load vars from hash, begin rounds
  input  sha256_pkg::word_t   hash_i [8],
  input  sha256_pkg::word_t   blk_i [16], // block words, big-endian packed
  output logic                done_o,    // pulse: vars_o valid
  output sha256_pkg::word_t   vars_o [8]
);

  sha256_pkg::word_t w_q [16];
  sha256_pkg::word_t v_q [8];
  logic [5:0] rnd_q;
  logic       busy_q;

  sha256_pkg::word_t w_cur, t1, t2, big0, big1, ch, maj;

  always_comb begin
    if (rnd_q < 6'd16) begin
      w_cur = w_q[rnd_q[3:0]];
    end else begin
      w_cur = sha256_pkg::sched_word(w_q[rnd_q[3:0]], w_q[4'(rnd_q - 6'd15)],
                                     w_q[4'(rnd_q - 6'd7)], w_q[4'(rnd_q - 6'd2)]);
    end
    big1 = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11) ^
           sha256_pkg::rotr(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + sha256_pkg::RoundK[rnd_q] + w_cur;
    big0 = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13) ^
           sha256_pkg::rotr(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= hash_i;
      w_q <= blk_i;
    end else if (busy_q) begin
      w_q[rnd_q[3:0]] <= w_cur;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign vars_o = v_q;

endmodule

// ===== hdl/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: block buffer memory, padding
// sequencer and digest output. Depends on sha256_pkg and sha256_core.
//
// Channel   Dir  tdata bits                         tuser / tlast
// s_axis    in   [7:0] data_byte                    tuser[0] op (1 = finish)
// m_axis    out  [31:0] digest_word, [34:32] index  tlast = last_word
//
// An absorb item writes its byte into the block memory and then passes through
// the StGap handshake turnaround before the next item is taken; the 64th byte
// of a block instead adds an unload of the memory into the core, the rounds and
// the hash update. A finish item writes padding one byte a cycle, runs one or
// two compressions, then offers the eight digest words one per cycle, each held
// while m_axis_tready is low. Reset is asynchronous and active low and needs no
// clearing pass; the block buffer is undefined until written.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
  output logic        m_axis_tlast    // last_word
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StLoad  = 7'b0000010,
    StRun   = 7'b0000100,
    StPad   = 7'b0001000,
    StLen   = 7'b0010000,
    StOut   = 7'b0100000,
    StGap   = 7'b1000000
  } state_e;

  state_e state_q;
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic        fin_q;     // compressing as part of a finish
  logic        final_q;   // this compression is the last of the message
  logic [4:0]  ld_q;      // unload counter: memory address stage
  logic [2:0]  oidx_q;
  sha256_pkg::word_t hash_q [8];
  sha256_pkg::word_t blk_q [16];

  // Block buffer: 16 words of 32 bits, byte-write, registered read.
  logic [31:0] mem [16];
  logic        mem_we;
  logic [5:0]  mem_waddr;
  logic [7:0]  mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      unique case (mem_waddr[1:0])
        2'd0: mem[mem_waddr[5:2]][31:24] <= mem_wdata;
        2'd1: mem[mem_waddr[5:2]][23:16] <= mem_wdata;
        2'd2: mem[mem_waddr[5:2]][15:8]  <= mem_wdata;
        default: mem[mem_waddr[5:2]][7:0] <= mem_wdata;
      endcase
    end
    mem_rdata <= mem[mem_raddr];
  end

  logic s_acc, m_acc, core_start, core_done;
  sha256_pkg::word_t core_vars [8];

  assign s_axis_tready = (state_q == StIdle);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  // The core starts once the last block word has landed in blk_q.
  assign core_start = (state_q == StLoad) && (ld_q == 5'd17);

  sha256_core u_core (
    .clk_i, .rst_ni, .start_i(core_start), .hash_i(hash_q), .blk_i(blk_q),
    .done_o(core_done), .vars_o(core_vars)
  );

  // Length bytes go in big-endian at positions 56..63.
  logic [7:0] len_byte;
  always_comb begin
    len_byte = 8'(bits_q >> (6'd56 - {fill_q[2:0], 3'b000}));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_q;
    mem_wdata = s_axis_tdata;
    unique case (state_q)
      StIdle: mem_we = s_acc;
      StPad: begin
        mem_we = 1'b1;
        mem_wdata = '0;
      end
      StLen: begin
        mem_we = 1'b1;
        mem_wdata = len_byte;
      end
      default: mem_we = 1'b0;
    endcase
    if (state_q == StIdle && s_acc && s_axis_tuser) mem_wdata = sha256_pkg::PadByte;
  end
  assign mem_raddr = ld_q[3:0];

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {5'd0, oidx_q, hash_q[oidx_q]};
  assign m_axis_tlast  = (oidx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      bits_q  <= '0;
      fin_q   <= 1'b0;
      final_q <= 1'b0;
      ld_q    <= '0;
      oidx_q  <= '0;
      hash_q  <= sha256_pkg::InitHash;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (s_acc) begin
            fill_q <= fill_q + 6'd1;
            if (s_axis_tuser) begin
              bits_q <= bits_q + {55'd0, fill_q, 3'b000};
              fin_q  <= 1'b1;
              if (fill_q == 6'd63) begin
                final_q <= 1'b0;
                ld_q    <= '0;
                state_q <= StLoad;
              end else begin
                state_q <= (fill_q == 6'd55) ? StLen : StPad;
                final_q <= 1'b1;
              end
            end else if (fill_q == 6'd63) begin
              fin_q   <= 1'b0;
              final_q <= 1'b0;
              ld_q    <= '0;
              state_q <= StLoad;
            end else begin
              state_q <= StGap;
            end
          end
        end
        StGap: state_q <= StIdle;
        StPad: begin
          fill_q <= fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            final_q <= 1'b0;
            ld_q    <= '0;
            state_q <= StLoad;
          end else if (fill_q == 6'd55) begin
            final_q <= 1'b1;
            state_q <= StLen;
          end
        end
        StLen: begin
          fill_q <= fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            ld_q    <= '0;
            state_q <= StLoad;
          end
        end
        StLoad: begin
          // Address ld_q is read now; its data arrives in mem_rdata in the next cycle.
          if (ld_q != 5'd0 && ld_q != 5'd17) blk_q[4'(ld_q - 5'd1)] <= mem_rdata;
          if (ld_q == 5'd17) state_q <= StRun;
          else ld_q <= ld_q + 5'd1;
        end
        StRun: begin
          if (core_done) begin
            for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + core_vars[i];
            if (!fin_q) begin
              bits_q  <= bits_q + sha256_pkg::BlockBits;
              state_q <= StIdle;
            end else if (final_q) begin
              oidx_q  <= '0;
              state_q <= StOut;
            end else begin
              state_q <= StPad;  // second padding block, fill_q is 0
            end
          end
        end
        StOut: begin
          if (m_acc) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              hash_q  <= sha256_pkg::InitHash;
              fill_q  <= '0;
              bits_q  <= '0;
              fin_q   <= 1'b0;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== tb/sha256_byte_stream_hasher_test.sv =====
// Testbench for the SHA-256 byte stream hasher: drives byte and finish items,
// predicts each digest with an independent SHA-256 model, checks all output.
// Depends on sha256_pkg and sha256_byte_stream_hasher.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test;

  localparam logic OpAbsorb = 1'b0;
  localparam logic OpFinish = 1'b1;
  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  byte_item_t   pending_bytes[$];
  digest_item_t expected_words[$];
  bit           stimulus_done = 1'b0;
  bit           failed = 1'b0;
  bit           calm = 1'b0;
  int           hold_off = 0;
  int           cycle_count = 0;

  // Predictor state.
  logic [31:0] hash_state[8];
  logic [7:0]  msg_block[64];
  int          block_fill;
  logic [63:0] bit_length;

  sha256_byte_stream_hasher DUT (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] ror32(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_predicted();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
             + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + sha256_pkg::RoundK[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::InitHash[i];
    block_fill = 0;
    bit_length = '0;
  endtask

  // Runs one accepted item through the predictor and queues any digest words.
  task automatic predict_item(byte_item_t it);
    int pos;
    if (it.op == OpAbsorb) begin
      msg_block[block_fill] = it.data_byte;
      block_fill++;
      if (block_fill == 64) begin
        compress_predicted();
        bit_length += sha256_pkg::BlockBits;
        block_fill = 0;
      end
    end else begin
      bit_length += 64'(block_fill) * 8;
      pos = block_fill;
      msg_block[pos++] = sha256_pkg::PadByte;
      if (pos > 56) begin
        while (pos < 64) msg_block[pos++] = 8'h00;
        compress_predicted();
        pos = 0;
      end
      while (pos < 56) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = bit_length[63-8*i -: 8];
      compress_predicted();
      for (int i = 0; i < 8; i++)
        expected_words.push_back('{hash_state[i], 3'(i), i == 7});
      restart_message();
    end
  endtask

  task automatic queue_message(int len, bit ones_only);
    for (int i = 0; i < len; i++)
      pending_bytes.push_back('{OpAbsorb, ones_only ? 8'hff : 8'($urandom_range(0, 255))});
    pending_bytes.push_back('{OpFinish, 8'($urandom_range(0, 255))});
  endtask

  // Driver: offers items at random, keeps valid high across back-to-back items.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item('{s_axis_tuser, s_axis_tdata});
        void'(pending_bytes.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready) && pending_bytes.size() > 0
          && (calm || $urandom_range(0, 99) >= 14)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_bytes[0].op;
        s_axis_tdata  <= pending_bytes[0].data_byte;
      end else if (!s_axis_tvalid || s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The driver pops only after acceptance, so pending_bytes[0] is what is on the bus;
  // a new item is loaded only after the previous one was popped in the same step.

  // Receiver: random stalls plus one long hold-off.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (cycle_count == 3000) begin
      hold_off <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || $urandom_range(0, 99) >= 14;
    end
  end

  // Monitor: compares each accepted digest word with the oldest prediction.
  always @(posedge clk_i) begin
    digest_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected digest word %h", $time, m_axis_tdata);
        failed <= 1'b1;
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata[31:0] !== want.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time, want.digest_word,
                   m_axis_tdata[31:0]);
          failed <= 1'b1;
        end
        if (m_axis_tdata[34:32] !== want.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time, want.word_index,
                   m_axis_tdata[34:32]);
          failed <= 1'b1;
        end
        if (m_axis_tlast !== want.last_word) begin
          $display("%0t: last_word expected %b actual %b", $time, want.last_word,
                   m_axis_tlast);
          failed <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    calm <= (cycle_count >= 8000 && cycle_count < 11000);
    if (cycle_count >= CycleLimit) begin
      $display("sha256_byte_stream_hasher_test failed");
      $finish;
    end
  end

  initial begin
    restart_message();
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    // Directed: empty message, one byte of all ones and of zero, the padding
    // boundaries at 55, 56 and 64 bytes, and a back-to-back finish.
    pending_bytes.push_back('{OpFinish, 8'hff});
    queue_message(1, 1'b1);
    pending_bytes.push_back('{OpAbsorb, 8'h00});
    pending_bytes.push_back('{OpFinish, 8'h00});
    queue_message(55, 1'b0);
    queue_message(56, 1'b0);
    queue_message(64, 1'b1);
    pending_bytes.push_back('{OpFinish, 8'h5a});
    // Random: mostly short messages, a few spanning several blocks.
    while (pending_bytes.size() < 350) begin
      if ($urandom_range(0, 9) == 0) queue_message($urandom_range(60, 140), 1'b0);
      else queue_message($urandom_range(0, 12), 1'b0);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_bytes.size() == 0);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk_i);
    if (!failed && expected_words.size() == 0) begin
      $display("sha256_byte_stream_hasher_test passed");
    end else begin
      $display("sha256_byte_stream_hasher_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sha256_pkg.sv
hdl/sha256_core.sv
hdl/sha256_byte_stream_hasher.sv
tb/sha256_byte_stream_hasher_test.sv
